// ----- rtl/water_heater_thermostat_controller_macros.svh -----
// Assertion macros for the water heater thermostat controller.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef WATER_HEATER_THERMOSTAT_CONTROLLER_MACROS_SVH
`define WATER_HEATER_THERMOSTAT_CONTROLLER_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define WHT_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define WHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/wht_pkg.sv -----
// Shared types, codes and helpers for the water heater thermostat controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wht_pkg;

  // Default geometry
  localparam int unsigned WINDOW_DEF     = 10;
  localparam int unsigned BLINK_HALF_DEF = 10;

  // Running sum of the sample ring
  localparam int unsigned SUM_W = 12;

  // Request kinds
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SAMPLE = 3'd1;
  localparam logic [2:0] KIND_UP     = 3'd2;
  localparam logic [2:0] KIND_DOWN   = 3'd3;
  localparam logic [2:0] KIND_POWER  = 3'd4;

  // Mode codes as seen on the status channel
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_HEAT  = 2'd1;
  localparam logic [1:0] MODE_SETUP = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_MIN_SETPOINT     = 3'd0;
  localparam logic [2:0] REG_MAX_SETPOINT     = 3'd1;
  localparam logic [2:0] REG_DEFAULT_SETPOINT = 3'd2;
  localparam logic [2:0] REG_SETPOINT_STEP    = 3'd3;
  localparam logic [2:0] REG_SETUP_TIMEOUT    = 3'd4;

  // Register reset values
  localparam logic [7:0] MIN_SETPOINT_RST     = 8'd35;
  localparam logic [7:0] MAX_SETPOINT_RST     = 8'd75;
  localparam logic [7:0] DEFAULT_SETPOINT_RST = 8'd60;
  localparam logic [3:0] SETPOINT_STEP_RST    = 4'd5;
  localparam logic [5:0] SETUP_TIMEOUT_RST    = 6'd50;

  // Setpoint and display after reset
  localparam logic [7:0] TEMP_RST = 8'd60;

  typedef enum logic [2:0] {
    ST_OFF   = 3'b001,
    ST_HEAT  = 3'b010,
    ST_SETUP = 3'b100
  } mode_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] reading;
    logic [7:0] saved_setpoint;
  } req_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       heater_on;
    logic       cooler_on;
    logic       led_on;
    logic       display_on;
    logic [7:0] shown_temp;
    logic [4:0] shown_tens;
    logic [3:0] shown_ones;
    logic [7:0] setpoint;
    logic       save_request;
  } status_t;

  function automatic logic [1:0] mode_code(input mode_state_t st);
    logic [1:0] code;
    unique case (st)
      ST_HEAT:  code = MODE_HEAT;
      ST_SETUP: code = MODE_SETUP;
      default:  code = MODE_OFF;
    endcase
    return code;
  endfunction

  // v / 10 for v < 1029
  function automatic logic [4:0] tens_of(input logic [7:0] v);
    logic [15:0] prod;
    prod = 16'(v) * 16'd205;
    return prod[15:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [7:0] v);
    logic [4:0] t;
    logic [7:0] rem;
    t   = tens_of(v);
    rem = v - (8'(t) * 8'd10);
    return rem[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/water_heater_thermostat_controller.sv -----
// Status is registered on accept; one request per cycle unless the status channel stalls.
// The sample ring sits in a one-read one-write memory; its read address is the next oldest
// slot, registered ahead of use, so the entry a full-ring sample replaces is ready at accept.
// Synchronous active-high reset: off mode, setpoint and display 60, ring empty, drives off,
// registers at their reset values. Ring contents are not cleared; only filled slots are used.
// Depends on wht_pkg and water_heater_thermostat_controller_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module water_heater_thermostat_controller #(
  parameter int unsigned WINDOW           = wht_pkg::WINDOW_DEF,
  parameter int unsigned BLINK_HALF_TICKS = wht_pkg::BLINK_HALF_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // request channel
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire wht_pkg::req_t    req,
  // status channel
  output logic                  status_valid,
  input  wire logic             status_ready,
  output wht_pkg::status_t      status,
  // APB register port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = wht_pkg::SUM_W;

  // Average = sum / WINDOW as (sum * M) >> 16; exact for 12-bit sums and WINDOW <= 16.
  localparam int unsigned AVG_SHIFT = 16;
  localparam logic [15:0] AVG_MULT  = 16'(((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW);
  localparam int unsigned PROD_W    = SUM_W + 16;

  localparam logic [5:0] BLINK_HALF  = 6'(BLINK_HALF_TICKS);
  localparam logic [5:0] BLINK_CYCLE = 6'(2 * BLINK_HALF_TICKS);
  // Lamp counter wraps in 5 bits
  localparam logic [4:0] LAMP_WRAP   = 5'((2 * BLINK_HALF_TICKS) % 32);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] min_setpoint;
  logic [7:0] max_setpoint;
  logic [7:0] default_setpoint;
  logic [3:0] setpoint_step;
  logic [5:0] setup_timeout_ticks;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_setpoint        <= wht_pkg::MIN_SETPOINT_RST;
      max_setpoint        <= wht_pkg::MAX_SETPOINT_RST;
      default_setpoint    <= wht_pkg::DEFAULT_SETPOINT_RST;
      setpoint_step       <= wht_pkg::SETPOINT_STEP_RST;
      setup_timeout_ticks <= wht_pkg::SETUP_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        wht_pkg::REG_MIN_SETPOINT:     min_setpoint        <= pwdata[7:0];
        wht_pkg::REG_MAX_SETPOINT:     max_setpoint        <= pwdata[7:0];
        wht_pkg::REG_DEFAULT_SETPOINT: default_setpoint    <= pwdata[7:0];
        wht_pkg::REG_SETPOINT_STEP:    setpoint_step       <= pwdata[3:0];
        wht_pkg::REG_SETUP_TIMEOUT:    setup_timeout_ticks <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      wht_pkg::REG_MIN_SETPOINT:     prdata = {24'd0, min_setpoint};
      wht_pkg::REG_MAX_SETPOINT:     prdata = {24'd0, max_setpoint};
      wht_pkg::REG_DEFAULT_SETPOINT: prdata = {24'd0, default_setpoint};
      wht_pkg::REG_SETPOINT_STEP:    prdata = {28'd0, setpoint_step};
      wht_pkg::REG_SETUP_TIMEOUT:    prdata = {26'd0, setup_timeout_ticks};
      default:                       prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  wht_pkg::mode_state_t mode_st, mode_st_next;
  logic [7:0]        wanted_temp, wanted_temp_next;
  logic [7:0]        display_temp, display_temp_next;
  logic              sample_due, sample_due_next;
  logic [SUM_W-1:0]  ring_sum, ring_sum_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [IDX_W-1:0]  oldest_slot, oldest_slot_next;
  logic [5:0]        blink_ticks, blink_ticks_next;
  logic [5:0]        idle_ticks, idle_ticks_next;
  logic [4:0]        lamp_ticks, lamp_ticks_next;
  logic              heater, heater_next;
  logic              cooler, cooler_next;
  logic              led, led_next;
  logic              save_flag, save_next;

  // Sample ring memory: one write port, one registered read port
  logic [7:0]        sample_ring [WINDOW];
  logic [7:0]        ring_rdata;
  logic              ring_we;
  logic [IDX_W-1:0]  ring_waddr;

  logic              req_fire;
  logic              ring_full;
  logic [SUM_W-1:0]  sum_fill;
  logic [SUM_W-1:0]  sum_roll;
  logic [PROD_W-1:0] avg_prod;
  logic [7:0]        avg;
  logic [IDX_W-1:0]  slot_adv;
  logic [5:0]        blink_inc;
  logic [5:0]        idle_inc;
  logic [8:0]        dn_diff;
  logic [7:0]        dn_val;
  logic [8:0]        up_sum;
  logic [7:0]        up_val;
  logic              saved_ok;
  logic              display_on;

  // Output register holds one status; a new request is taken as the old one leaves
  assign req_ready = !status_valid || status_ready;
  assign req_fire  = req_valid && req_ready;

  assign ring_full = (fill_count == FILL_W'(WINDOW));
  assign sum_fill  = ring_sum + SUM_W'(req.reading);
  // Entry leaving the window comes from the read issued last cycle at oldest_slot
  assign sum_roll  = ring_sum + SUM_W'(req.reading) - SUM_W'(ring_rdata);
  assign avg_prod  = PROD_W'(sum_roll) * PROD_W'(AVG_MULT);
  assign avg       = avg_prod[AVG_SHIFT +: 8];
  assign slot_adv  = (oldest_slot == IDX_W'(WINDOW - 1)) ? '0 : oldest_slot + 1'b1;

  assign blink_inc = blink_ticks + 1'b1;
  assign idle_inc  = idle_ticks + 1'b1;

  // Down step saturates at the minimum, up step at the maximum
  assign dn_diff = {1'b0, wanted_temp} - {5'd0, setpoint_step};
  assign dn_val  = (dn_diff[8] || (dn_diff[7:0] < min_setpoint)) ? min_setpoint : dn_diff[7:0];
  assign up_sum  = {1'b0, wanted_temp} + {5'd0, setpoint_step};
  assign up_val  = (up_sum > {1'b0, max_setpoint}) ? max_setpoint : up_sum[7:0];

  assign saved_ok = (req.saved_setpoint >= min_setpoint) &&
                    (req.saved_setpoint <= max_setpoint);

  always_comb begin
    mode_st_next      = mode_st;
    wanted_temp_next  = wanted_temp;
    display_temp_next = display_temp;
    sample_due_next   = sample_due;
    ring_sum_next     = ring_sum;
    fill_count_next   = fill_count;
    oldest_slot_next  = oldest_slot;
    blink_ticks_next  = blink_ticks;
    idle_ticks_next   = idle_ticks;
    lamp_ticks_next   = lamp_ticks;
    heater_next       = heater;
    cooler_next       = cooler;
    led_next          = led;
    save_next         = 1'b0;
    ring_we           = 1'b0;
    ring_waddr        = oldest_slot;

    if (req_fire) begin
      unique case (req.kind)
        wht_pkg::KIND_TICK: begin
          // Tick re-arms sampling
          if (mode_st != wht_pkg::ST_OFF) begin
            sample_due_next = 1'b0;
          end
          if (mode_st == wht_pkg::ST_SETUP) begin
            blink_ticks_next = (blink_inc >= BLINK_CYCLE) ? '0 : blink_inc;
            idle_ticks_next  = idle_inc;
            // Timeout of zero lands after the 6-bit counter wraps
            if (idle_inc == setup_timeout_ticks) begin
              blink_ticks_next = '0;
              mode_st_next     = wht_pkg::ST_HEAT;
            end
          end
        end

        wht_pkg::KIND_SAMPLE: begin
          if (mode_st == wht_pkg::ST_HEAT && !sample_due) begin
            sample_due_next = 1'b1;
            ring_we         = 1'b1;
            if (!ring_full) begin
              // Filling: no regulation yet, show the setpoint
              ring_sum_next     = sum_fill;
              ring_waddr        = fill_count[IDX_W-1:0];
              fill_count_next   = fill_count + 1'b1;
              display_temp_next = wanted_temp;
            end else begin
              ring_sum_next     = sum_roll;
              oldest_slot_next  = slot_adv;
              display_temp_next = avg;
              if (wanted_temp < avg) begin
                heater_next     = 1'b0;
                cooler_next     = 1'b1;
                led_next        = 1'b1;
                lamp_ticks_next = LAMP_WRAP;
              end else if (wanted_temp > avg) begin
                // Heating: lamp blinks on the lamp counter
                heater_next = 1'b1;
                cooler_next = 1'b0;
                if ({1'b0, lamp_ticks} == BLINK_HALF) begin
                  led_next        = 1'b1;
                  lamp_ticks_next = lamp_ticks + 1'b1;
                end else if ({1'b0, lamp_ticks} == BLINK_CYCLE) begin
                  led_next        = 1'b0;
                  lamp_ticks_next = '0;
                end else begin
                  lamp_ticks_next = lamp_ticks + 1'b1;
                end
              end else begin
                heater_next = 1'b0;
                cooler_next = 1'b0;
              end
            end
          end
        end

        wht_pkg::KIND_UP, wht_pkg::KIND_DOWN: begin
          if (mode_st == wht_pkg::ST_HEAT) begin
            // First press only enters setup
            mode_st_next      = wht_pkg::ST_SETUP;
            heater_next       = 1'b0;
            cooler_next       = 1'b0;
            led_next          = 1'b0;
            display_temp_next = wanted_temp;
            idle_ticks_next   = '0;
            blink_ticks_next  = '0;
          end else if (mode_st == wht_pkg::ST_SETUP) begin
            idle_ticks_next  = '0;
            blink_ticks_next = '0;
            if (req.kind == wht_pkg::KIND_DOWN) begin
              if (wanted_temp > min_setpoint) begin
                wanted_temp_next  = dn_val;
                display_temp_next = dn_val;
              end
            end else if (wanted_temp < max_setpoint) begin
              wanted_temp_next  = up_val;
              display_temp_next = up_val;
            end
          end
        end

        wht_pkg::KIND_POWER: begin
          if (mode_st == wht_pkg::ST_OFF) begin
            wanted_temp_next = saved_ok ? req.saved_setpoint : default_setpoint;
            mode_st_next     = wht_pkg::ST_HEAT;
          end else begin
            // Power-down: empty the ring logically, stop drives, ask for a save
            mode_st_next     = wht_pkg::ST_OFF;
            heater_next      = 1'b0;
            cooler_next      = 1'b0;
            led_next         = 1'b0;
            sample_due_next  = 1'b0;
            ring_sum_next    = '0;
            fill_count_next  = '0;
            oldest_slot_next = '0;
            blink_ticks_next = '0;
            idle_ticks_next  = '0;
            lamp_ticks_next  = '0;
            save_next        = 1'b1;
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_st      <= wht_pkg::ST_OFF;
      wanted_temp  <= wht_pkg::TEMP_RST;
      display_temp <= wht_pkg::TEMP_RST;
      sample_due   <= 1'b0;
      ring_sum     <= '0;
      fill_count   <= '0;
      oldest_slot  <= '0;
      blink_ticks  <= '0;
      idle_ticks   <= '0;
      lamp_ticks   <= '0;
      heater       <= 1'b0;
      cooler       <= 1'b0;
      led          <= 1'b0;
      save_flag    <= 1'b0;
      status_valid <= 1'b0;
    end else begin
      mode_st      <= mode_st_next;
      wanted_temp  <= wanted_temp_next;
      display_temp <= display_temp_next;
      sample_due   <= sample_due_next;
      ring_sum     <= ring_sum_next;
      fill_count   <= fill_count_next;
      oldest_slot  <= oldest_slot_next;
      blink_ticks  <= blink_ticks_next;
      idle_ticks   <= idle_ticks_next;
      lamp_ticks   <= lamp_ticks_next;
      heater       <= heater_next;
      cooler       <= cooler_next;
      led          <= led_next;
      if (req_fire) begin
        save_flag <= save_next;
      end
      if (req_fire) begin
        status_valid <= 1'b1;
      end else if (status_ready) begin
        status_valid <= 1'b0;
      end
    end
  end

  // Read runs one slot ahead: on a full ring the written slot never equals the read slot
  always_ff @(posedge clk) begin
    if (ring_we) begin
      sample_ring[ring_waddr] <= req.reading;
    end
    ring_rdata <= sample_ring[oldest_slot_next];
  end

  // ---------------------------------------------------------------------------
  // Status: state only changes on a taken request, so it doubles as the payload
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (mode_st)
      wht_pkg::ST_HEAT:  display_on = 1'b1;
      wht_pkg::ST_SETUP: display_on = (blink_ticks < BLINK_HALF);
      default:           display_on = 1'b0;
    endcase
  end

  assign status = '{
    mode:         wht_pkg::mode_code(mode_st),
    heater_on:    heater,
    cooler_on:    cooler,
    led_on:       led,
    display_on:   display_on,
    shown_temp:   display_temp,
    shown_tens:   wht_pkg::tens_of(display_temp),
    shown_ones:   wht_pkg::ones_of(display_temp),
    setpoint:     wanted_temp,
    save_request: save_flag
  };

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `include "water_heater_thermostat_controller_macros.svh"

  `WHT_ASSERT_NOW(a_fill_bound, fill_count <= FILL_W'(WINDOW), "ring fill count past window")
  `WHT_ASSERT_IMP(a_slot_when_full, oldest_slot != '0, ring_full, "ring slot moved before full")
  `WHT_ASSERT_NOW(a_drive_excl, !(heater && cooler), "heater and cooler both on")
  `WHT_ASSERT_IMP(a_save_off, status_valid && status.save_request, status.mode == wht_pkg::MODE_OFF, "save request outside off mode")
  `WHT_ASSERT_IMP(a_off_quiet, mode_st == wht_pkg::ST_OFF, !heater && !cooler && !led && fill_count == '0, "off mode with drives or samples")

endmodule

`default_nettype wire
